// File: src/sine_table_interpolator_assert.svh
// Assertion macros shared by the sine table interpolator RTL.
`ifndef SINE_TABLE_INTERPOLATOR_ASSERT_SVH
`define SINE_TABLE_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define STI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sine table interpolator: same-cycle check failed");
`define STI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sine table interpolator: next-cycle check failed");
`else
`define STI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define STI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/sti_pkg.sv
package sti_pkg;

  localparam int unsigned NumStages = 6;
  localparam int unsigned StageIdxW = $clog2(NumStages);

  localparam logic [1:0] OPC_ANGLE8  = 2'd0;
  localparam logic [1:0] OPC_ANGLE16 = 2'd1;

  localparam logic signed [31:0] COEF_16 = 32'sd2527;
  localparam logic signed [31:0] COEF_32 = 32'sd1324675879;
  localparam logic signed [56:0] Q31_MAX = 57'sh7FFFFFFF;

  localparam logic [31:0] QUARTER_ROM [65] = '{
    32'h00000000, 32'h03242ABF, 32'h0647D97C, 32'h096A9049,
    32'h0C8BD35E, 32'h0FAB272B, 32'h12C8106F, 32'h15E21445,
    32'h18F8B83C, 32'h1C0B826A, 32'h1F19F97B, 32'h2223A4C5,
    32'h25280C5E, 32'h2826B928, 32'h2B1F34EB, 32'h2E110A62,
    32'h30FBC54D, 32'h33DEF287, 32'h36BA2014, 32'h398CDD32,
    32'h3C56BA70, 32'h3F1749B8, 32'h41CE1E65, 32'h447ACD50,
    32'h471CECE7, 32'h49B41533, 32'h4C3FDFF4, 32'h4EBFE8A5,
    32'h5133CC94, 32'h539B2AF0, 32'h55F5A4D2, 32'h5842DD54,
    32'h5A82799A, 32'h5CB420E0, 32'h5ED77C8A, 32'h60EC3830,
    32'h62F201AC, 32'h64E88926, 32'h66CF8120, 32'h68A69E81,
    32'h6A6D98A4, 32'h6C242960, 32'h6DCA0D14, 32'h6F5F02B2,
    32'h70E2CBC6, 32'h72552C85, 32'h73B5EBD1, 32'h7504D345,
    32'h7641AF3D, 32'h776C4EDB, 32'h78848414, 32'h798A23B1,
    32'h7A7D055B, 32'h7B5D039E, 32'h7C29FBEE, 32'h7CE3CEB2,
    32'h7D8A5F40, 32'h7E1D93EA, 32'h7E9D55FC, 32'h7F0991C4,
    32'h7F62368F, 32'h7FA736B4, 32'h7FD8878E, 32'h7FF62182,
    32'h7FFFFFFF
  };

  function automatic logic signed [32:0] sine8(input logic [7:0] ph);
    logic [6:0]         idx;
    logic signed [32:0] mag;
    idx = ph[6] ? (7'd64 - {1'b0, ph[5:0]}) : {1'b0, ph[5:0]};
    mag = $signed({1'b0, QUARTER_ROM[idx]});
    return ph[7] ? -mag : mag;
  endfunction

endpackage

// File: src/sine_table_interpolator.sv
// Quarter-wave sine table with interpolation. Each request carries a precision
// selector in tuser (0: 8-bit angle, 1: 16-bit angle, 2 or 3: 32-bit angle) and
// the angle in tdata; one full turn is 2^bits. The result is the sine in Q31,
// saturated to +/-0x7FFFFFFF. The block is a six-stage pipeline (two table
// reads, a linear-step multiplier, the correction multipliers, and the final
// subtract and saturate in the output register), and one request can be taken
// every cycle unless the pipeline is full and the output is stalled.
// Each stage holds its request while the next is full and held, so a stall at
// the output does not stop the input until the pipeline has filled.

`include "sine_table_interpolator_assert.svh"

module sine_table_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // angle[31:0]
  input  logic [1:0]  s_axis_tuser_i,   // opcode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // sine_value[31:0]
);

  logic [sti_pkg::NumStages-1:0] vld_q;
  logic [sti_pkg::NumStages-1:0] adv;

  always_comb begin
    adv[sti_pkg::NumStages-1] = !vld_q[sti_pkg::NumStages-1] || m_axis_tready_i;
    for (int k = sti_pkg::NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = vld_q[sti_pkg::NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < sti_pkg::NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: table reads of the point and the next point.
  logic [7:0]         hi;
  logic [24:0]        frac;
  logic [1:0]         s1_mode_q;
  logic [24:0]        s1_frac_q;
  logic signed [32:0] s1_v0_q, s1_nx_q;

  always_comb begin
    case (s_axis_tuser_i)
      sti_pkg::OPC_ANGLE8:  hi = s_axis_tdata_i[7:0];
      sti_pkg::OPC_ANGLE16: hi = s_axis_tdata_i[15:8];
      default:              hi = s_axis_tdata_i[31:24];
    endcase
    frac = (s_axis_tuser_i == sti_pkg::OPC_ANGLE16) ? {17'd0, s_axis_tdata_i[7:0]}
                                                    : {1'b0, s_axis_tdata_i[23:0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && s_axis_tvalid_i) begin
      s1_mode_q <= s_axis_tuser_i;
      s1_frac_q <= frac;
      s1_v0_q   <= sti_pkg::sine8(hi);
      s1_nx_q   <= sti_pkg::sine8(hi + 8'd1);
    end
  end

  // Stage 2: linear step product and the parabola of the fraction.
  logic               s1_is16;
  logic signed [33:0] diff, mul_b;
  logic signed [24:0] mul_a;
  logic signed [25:0] fk, fm;
  logic [1:0]         s2_mode_q;
  logic signed [32:0] s2_v0_q;
  logic signed [58:0] s2_prod_q;
  logic signed [50:0] s2_fprod_q;

  always_comb begin
    s1_is16 = (s1_mode_q == sti_pkg::OPC_ANGLE16);
    diff    = 34'(s1_nx_q) - 34'(s1_v0_q);
    mul_b   = s1_is16 ? (diff >>> 8) : diff;
    mul_a   = $signed(s1_frac_q);
    fk      = s1_is16 ? 26'sd256 : 26'sh1000000;
    fm      = 26'(mul_a) - fk;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1] && vld_q[0]) begin
      s2_mode_q  <= s1_mode_q;
      s2_v0_q    <= s1_v0_q;
      s2_prod_q  <= 59'(mul_a) * 59'(mul_b);
      s2_fprod_q <= 51'(mul_a) * 51'(fm);
    end
  end

  // Stage 3: interpolated value.
  logic               s2_is16;
  logic signed [58:0] vsum;
  logic [1:0]         s3_mode_q;
  logic signed [33:0] s3_v_q;
  logic signed [15:0] s3_f2_q;

  always_comb begin
    s2_is16 = (s2_mode_q == sti_pkg::OPC_ANGLE16);
    vsum    = 59'(s2_v0_q) + (s2_is16 ? s2_prod_q : (s2_prod_q >>> 24));
  end

  always_ff @(posedge clk_i) begin
    if (adv[2] && vld_q[1]) begin
      s3_mode_q <= s2_mode_q;
      s3_v_q    <= (s2_mode_q == sti_pkg::OPC_ANGLE8) ? 34'(s2_v0_q) : 34'(vsum);
      s3_f2_q   <= s2_is16 ? 16'(s2_fprod_q) : 16'(s2_fprod_q >>> 32);
    end
  end

  // Stage 4: second-derivative estimate.
  logic               s3_is16;
  logic signed [33:0] der_a;
  logic signed [31:0] der_coef;
  logic [1:0]         s4_mode_q;
  logic signed [33:0] s4_v_q;
  logic signed [15:0] s4_f2_q;
  logic signed [65:0] s4_der_q;

  always_comb begin
    s3_is16  = (s3_mode_q == sti_pkg::OPC_ANGLE16);
    der_a    = s3_is16 ? (s3_v_q >>> 12) : s3_v_q;
    der_coef = s3_is16 ? sti_pkg::COEF_16 : sti_pkg::COEF_32;
  end

  always_ff @(posedge clk_i) begin
    if (adv[3] && vld_q[2]) begin
      s4_mode_q <= s3_mode_q;
      s4_v_q    <= s3_v_q;
      s4_f2_q   <= s3_f2_q;
      s4_der_q  <= 66'(der_a) * 66'(der_coef);
    end
  end

  // Stage 5: correction product.
  logic signed [39:0] der_s;
  logic [1:0]         s5_mode_q;
  logic signed [33:0] s5_v_q;
  logic signed [55:0] s5_corr_q;

  always_comb begin
    der_s = (s4_mode_q == sti_pkg::OPC_ANGLE16) ? 40'(s4_der_q >>> 16)
                                                : 40'(s4_der_q >>> 26);
  end

  always_ff @(posedge clk_i) begin
    if (adv[4] && vld_q[3]) begin
      s5_mode_q <= s4_mode_q;
      s5_v_q    <= s4_v_q;
      s5_corr_q <= 56'(der_s) * 56'(s4_f2_q);
    end
  end

  // Stage 6: subtract the correction and saturate into the output register.
  logic signed [55:0] corr;
  logic signed [56:0] res;
  logic [31:0]        sat;
  logic [31:0]        out_q;

  always_comb begin
    case (s5_mode_q)
      sti_pkg::OPC_ANGLE8:  corr = 56'sd0;
      sti_pkg::OPC_ANGLE16: corr = s5_corr_q >>> 11;
      default:              corr = s5_corr_q >>> 32;
    endcase
    res = 57'(s5_v_q) - 57'(corr);
    if (res > sti_pkg::Q31_MAX) begin
      sat = 32'h7FFFFFFF;
    end else if (res < -sti_pkg::Q31_MAX) begin
      sat = 32'h80000001;
    end else begin
      sat = res[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5] && vld_q[4]) begin
      out_q <= sat;
    end
  end

  assign m_axis_tdata_o = out_q;

  `STI_ASSERT_NEXT(a_accept_fills_first, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, vld_q[0])
  `STI_ASSERT_IMPLIES(a_busy_means_full, clk_i, rst_ni, !s_axis_tready_o, vld_q[0] && vld_q[1])
  `STI_ASSERT_NEXT(a_stalled_stage_holds, clk_i, rst_ni, vld_q[2] && !adv[2], vld_q[2])
  `STI_ASSERT_IMPLIES(a_saturated_range, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o != 32'h80000000)

endmodule

// File: bench/sine_checker.sv
// Predicts the sine for every accepted request and compares it with the results in order.
module sine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [31:0] req_angle_i,
  input  logic [1:0]  req_opcode_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [31:0] res_sine_i,
  output int          fails_o,
  output int          pending_o
);

  localparam longint signed SatLimit   = 64'sh7FFF_FFFF;
  localparam longint signed CorrCoef16 = 64'sd2527;
  localparam longint signed CorrCoef32 = 64'sd1324675879;
  localparam longint signed FracOne32  = 64'sh100_0000;

  localparam logic [31:0] quarter_wave [65] = '{
    32'h00000000, 32'h03242ABF, 32'h0647D97C, 32'h096A9049,
    32'h0C8BD35E, 32'h0FAB272B, 32'h12C8106F, 32'h15E21445,
    32'h18F8B83C, 32'h1C0B826A, 32'h1F19F97B, 32'h2223A4C5,
    32'h25280C5E, 32'h2826B928, 32'h2B1F34EB, 32'h2E110A62,
    32'h30FBC54D, 32'h33DEF287, 32'h36BA2014, 32'h398CDD32,
    32'h3C56BA70, 32'h3F1749B8, 32'h41CE1E65, 32'h447ACD50,
    32'h471CECE7, 32'h49B41533, 32'h4C3FDFF4, 32'h4EBFE8A5,
    32'h5133CC94, 32'h539B2AF0, 32'h55F5A4D2, 32'h5842DD54,
    32'h5A82799A, 32'h5CB420E0, 32'h5ED77C8A, 32'h60EC3830,
    32'h62F201AC, 32'h64E88926, 32'h66CF8120, 32'h68A69E81,
    32'h6A6D98A4, 32'h6C242960, 32'h6DCA0D14, 32'h6F5F02B2,
    32'h70E2CBC6, 32'h72552C85, 32'h73B5EBD1, 32'h7504D345,
    32'h7641AF3D, 32'h776C4EDB, 32'h78848414, 32'h798A23B1,
    32'h7A7D055B, 32'h7B5D039E, 32'h7C29FBEE, 32'h7CE3CEB2,
    32'h7D8A5F40, 32'h7E1D93EA, 32'h7E9D55FC, 32'h7F0991C4,
    32'h7F62368F, 32'h7FA736B4, 32'h7FD8878E, 32'h7FF62182,
    32'h7FFFFFFF
  };

  logic signed [31:0] sine_expected_q [$];
  logic signed [31:0] want;
  int                 mismatches = 0;
  int                 depth = 0;

  assign fails_o   = mismatches;
  assign pending_o = depth;

  // The second half of the turn is negated and odd quadrants read the table backward.
  function automatic longint signed folded_sine(input logic [7:0] ph);
    logic [6:0]     idx;
    longint signed  mag;
    idx = ph[6] ? (7'd64 - {1'b0, ph[5:0]}) : {1'b0, ph[5:0]};
    mag = {32'd0, quarter_wave[idx]};
    return ph[7] ? -mag : mag;
  endfunction

  function automatic longint signed sine_angle16(input logic [15:0] a);
    logic [7:0]    hi;
    longint signed f, v, d, f2, der, corr;
    hi   = a[15:8];
    f    = {56'd0, a[7:0]};
    v    = folded_sine(hi);
    d    = (folded_sine(hi + 8'd1) - v) >>> 8;
    v    = v + f * d;
    f2   = f * (f - 64'sd256);
    der  = CorrCoef16 * (v >>> 12);
    corr = ((der >>> 16) * f2) >>> 11;
    return v - corr;
  endfunction

  function automatic longint signed sine_angle32(input logic [31:0] a);
    logic [7:0]    hi;
    longint signed f, v, d, f2, der, corr;
    hi   = a[31:24];
    f    = {40'd0, a[23:0]};
    v    = folded_sine(hi);
    d    = folded_sine(hi + 8'd1) - v;
    v    = v + ((f * d) >>> 24);
    f2   = (f * (f - FracOne32)) >>> 32;
    der  = (CorrCoef32 * v) >>> 26;
    corr = (der * f2) >>> 32;
    return v - corr;
  endfunction

  function automatic logic signed [31:0] predict_sine(input logic [1:0] opcode,
                                                      input logic [31:0] angle);
    longint signed v;
    case (opcode)
      sti_pkg::OPC_ANGLE8:  v = folded_sine(angle[7:0]);
      sti_pkg::OPC_ANGLE16: v = sine_angle16(angle[15:0]);
      default:              v = sine_angle32(angle);
    endcase
    if (v > SatLimit) v = SatLimit;
    if (v < -SatLimit) v = -SatLimit;
    return v[31:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && req_valid_i && req_ready_i) begin
      sine_expected_q.push_back(predict_sine(req_opcode_i, req_angle_i));
    end
    if (rst_ni && res_valid_i && res_ready_i) begin
      if (sine_expected_q.size() == 0) begin
        $error("sine_value: expected nothing, actual %0d", $signed(res_sine_i));
        mismatches++;
      end else begin
        want = sine_expected_q.pop_front();
        if (want !== $signed(res_sine_i)) begin
          $error("sine_value: expected %0d, actual %0d", want, $signed(res_sine_i));
          mismatches++;
        end
      end
    end
    depth = sine_expected_q.size();
  end

endmodule

// File: bench/testbench.sv
module testbench;

  localparam logic [1:0] OpcAngle32    = 2'd2;
  localparam logic [1:0] OpcAngle32Alt = 2'd3;
  localparam int         StallLimit    = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  int fails;
  int pending;
  int src_idle_pct = 32;
  int sink_idle_pct = 70;
  bit hold_pending = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  sine_table_interpolator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  sine_checker sine_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_angle_i  (s_axis_tdata),
    .req_opcode_i (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_sine_i   (m_axis_tdata),
    .fails_o      (fails),
    .pending_o    (pending)
  );

  // The result side stalls at random, or for a long stretch when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_angle(input logic [1:0] opcode, input logic [31:0] angle);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= opcode;
    s_axis_tdata  <= angle;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random_angles(input int count);
    logic [1:0]  opcode;
    logic [31:0] angle;
    for (int i = 0; i < count; i++) begin
      opcode = 2'($urandom_range(3));
      angle  = $urandom;
      // Bias some requests toward the ends of an interpolation segment.
      if ($urandom_range(3) == 0) begin
        angle[23:0] = {24{angle[0]}} ^ 24'($urandom_range(15));
        angle[7:0]  = {8{angle[1]}} ^ 8'($urandom_range(7));
      end
      send_angle(opcode, angle);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_angle(sti_pkg::OPC_ANGLE8, 32'h0000_0000);
    send_angle(sti_pkg::OPC_ANGLE8, 32'h0000_003F);
    send_angle(sti_pkg::OPC_ANGLE8, 32'h0000_0040);
    send_angle(sti_pkg::OPC_ANGLE8, 32'h0000_0080);
    send_angle(sti_pkg::OPC_ANGLE8, 32'h0000_00C0);
    send_angle(sti_pkg::OPC_ANGLE8, 32'hFFFF_FFFF);
    send_angle(sti_pkg::OPC_ANGLE8, 32'hABCD_EF41);
    send_angle(sti_pkg::OPC_ANGLE16, 32'h0000_0000);
    send_angle(sti_pkg::OPC_ANGLE16, 32'h0000_00FF);
    send_angle(sti_pkg::OPC_ANGLE16, 32'h0000_3FFF);
    send_angle(sti_pkg::OPC_ANGLE16, 32'h0000_4000);
    send_angle(sti_pkg::OPC_ANGLE16, 32'h0000_FF80);
    send_angle(sti_pkg::OPC_ANGLE16, 32'hFFFF_FFFF);
    send_angle(sti_pkg::OPC_ANGLE16, 32'h5A5A_C0FF);
    send_angle(OpcAngle32, 32'h0000_0000);
    send_angle(OpcAngle32, 32'h3FFF_FFFF);
    send_angle(OpcAngle32, 32'h4000_0001);
    send_angle(OpcAngle32, 32'h3F80_0000);
    send_angle(OpcAngle32, 32'hFF80_0000);
    send_angle(OpcAngle32, 32'hFFFF_FFFF);
    send_angle(OpcAngle32Alt, 32'h1234_5678);
    send_angle(OpcAngle32Alt, 32'hC000_0001);
    send_angle(OpcAngle32Alt, 32'h7FFF_FFFF);

    send_random_angles(180);

    src_idle_pct  = 70;
    sink_idle_pct = 32;
    send_random_angles(180);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_random_angles(20);
    hold_pending = 1'b1;
    send_random_angles(150);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
